// ===== rtl/lns_pkg.sv =====
// ----------------------------------------------------------------------------
// lns_pkg
// shared types and constants for the lattice noise sampler
// ----------------------------------------------------------------------------
`default_nettype none

package lns_pkg;

  typedef enum logic [1:0] {
    MODE_BIT_PAIR  = 2'd0,
    MODE_ZERO_PAIR = 2'd1,
    MODE_REJ_SIX   = 2'd2,
    MODE_REJ_TWLV  = 2'd3
  } mode_t;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [2:0] CAND_MASK  = 3'h7;
  localparam logic [2:0] CAND_LIMIT = 3'd6;
  localparam logic [3:0] NIB_LIMIT  = 4'd12;

  // one request worth of candidate samples, kept slots emitted low first
  typedef struct packed {
    logic [SLOTS-1:0]      keep;
    logic [SLOTS-1:0][1:0] smp;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/lns_front.sv =====
// ----------------------------------------------------------------------------
// lns_front
// takes input bytes, holds mode and chunk state, builds sample jobs
// ----------------------------------------------------------------------------
`default_nettype none

module lns_front import lns_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic [1:0] cfg_data,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_final,
  output job_t            job,
  output logic            job_push
);

  mode_t       mode_r, mode_nxt;
  logic [15:0] store_r, store_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic [23:0] chunk;
  logic [2:0]  cand;
  logic [3:0]  lo_nib, hi_nib;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_BIT_PAIR;
      store_r <= '0;
      fill_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      store_r <= store_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    store_nxt = store_r;
    fill_nxt  = fill_r;
    job       = '0;
    chunk     = {in_byte, store_r};
    lo_nib    = in_byte[3:0];
    hi_nib    = in_byte[7:4];
    cand      = '0;
    unique case (mode_r)
      MODE_BIT_PAIR: begin
        for (int k = 0; k < 4; k++) begin
          job.keep[k] = 1'b1;
          job.smp[k]  = {1'b0, in_byte[2*k+1]} - {1'b0, in_byte[2*k]};
        end
      end
      MODE_ZERO_PAIR: begin
        job.keep[1:0] = 2'b11;
        job.smp[0] = {1'b0, lo_nib[1:0] == 2'd0} - {1'b0, lo_nib[3:2] == 2'd0};
        job.smp[1] = {1'b0, hi_nib[1:0] == 2'd0} - {1'b0, hi_nib[3:2] == 2'd0};
      end
      MODE_REJ_SIX: begin
        if (fill_r >= 2'd2) begin
          for (int k = 0; k < SLOTS; k++) begin
            cand        = chunk[3*k +: 3] & CAND_MASK;
            job.keep[k] = cand < CAND_LIMIT;
            job.smp[k]  = {1'b0, cand == 3'd0};
          end
        end
        if (in_fire) begin
          if (fill_r >= 2'd2) begin
            store_nxt = '0;
            fill_nxt  = '0;
          end else if (fill_r == 2'd1) begin
            store_nxt = {in_byte, store_r[7:0]};
            fill_nxt  = 2'd2;
          end else begin
            store_nxt = {8'd0, in_byte};
            fill_nxt  = 2'd1;
          end
        end
      end
      MODE_REJ_TWLV: begin
        job.keep[0] = lo_nib < NIB_LIMIT;
        job.smp[0]  = {1'b0, lo_nib == 4'd0};
        job.keep[1] = hi_nib < NIB_LIMIT;
        job.smp[1]  = {1'b0, hi_nib == 4'd0};
      end
      default: job = '0;
    endcase
    if (in_fire && in_final) begin
      store_nxt = '0;
      fill_nxt  = '0;
    end
    if (cfg_valid) begin
      mode_nxt  = mode_t'(cfg_data);
      store_nxt = '0;
      fill_nxt  = '0;
    end
  end

  assign job_push = in_fire && (job.keep != '0);

endmodule

`default_nettype wire

// ===== rtl/lns_fifo.sv =====
// ----------------------------------------------------------------------------
// lns_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module lns_fifo import lns_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wdata,
  output logic      full,
  input  wire logic pop,
  output job_t      rdata,
  output logic      empty
);

  job_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  assign full  = count_r == FIFO_CW'(FIFO_DEPTH);
  assign empty = count_r == '0;
  assign rdata = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/lns_back.sv =====
// ----------------------------------------------------------------------------
// lns_back
// drains jobs one kept sample per cycle into the output register while out_ready allows
// ----------------------------------------------------------------------------
`default_nettype none

module lns_back import lns_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_avail,
  input  wire job_t       job_in,
  output logic            job_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_sample,
  output logic            out_last
);

  job_t             cur_r;
  logic [SLOTS-1:0] rem_r, rem_nxt;
  logic [SLOTS-1:0] pick;
  logic [1:0]       pick_smp;
  logic             valid_r;
  logic [1:0]       smp_r;
  logic             last_r;
  logic             out_load;
  logic             rem_done;

  always_comb begin
    pick     = '0;
    pick_smp = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (rem_r[k]) begin
        pick     = '0;
        pick[k]  = 1'b1;
        pick_smp = cur_r.smp[k];
      end
    end
  end

  assign out_load = (!valid_r || out_ready) && (rem_r != '0);
  assign rem_done = (rem_r & ~pick) == '0;
  assign job_pop  = job_avail && ((rem_r == '0) || (out_load && rem_done));

  always_comb begin
    rem_nxt = rem_r;
    if (out_load) rem_nxt = rem_r & ~pick;
    if (job_pop)  rem_nxt = job_in.keep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      if (out_load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) cur_r <= job_in;
    if (out_load) begin
      smp_r  <= pick_smp;
      last_r <= rem_done;
    end
  end

  assign out_valid  = valid_r;
  assign out_sample = smp_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

// ===== rtl/lattice_noise_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// lattice_noise_sampler_unit
// random bytes in, lattice noise samples or rejection zero flags out
// ----------------------------------------------------------------------------
// path: a byte's first result passes the job queue, the back end job register
// and the output register; results follow at one per cycle from the back end
// while out_tready is high; one byte in per cycle while the queue is not full.
// Samples: 4 per byte in mode 0, 2 in 1, up to 2 in 3, up to 8 per 3 in 2
// reset: synchronous active low, clears mode to 0, chunk state and queue
`default_nettype none

module lattice_noise_sampler_unit import lns_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data,      // sample_mode
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,      // [7:0] data_byte
  input  wire logic       in_tlast,      // final_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,     // [1:0] sample (signed), [7:2] zero
  output logic            out_tlast      // last_of_run
);

  job_t       push_job, head_job;
  logic       push, pop, full, empty;
  logic       in_fire;
  logic [1:0] smp;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  lns_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .in_byte  (in_tdata),
    .in_final (in_tlast),
    .job      (push_job),
    .job_push (push)
  );

  lns_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .wdata(push_job),
    .full (full),
    .pop  (pop),
    .rdata(head_job),
    .empty(empty)
  );

  lns_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (!empty),
    .job_in    (head_job),
    .job_pop   (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sample(smp),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'd0, smp};

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("job popped from empty queue");

  a_empty_job: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_job.keep != '0))
    else $error("queued job without kept samples");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && empty)
    else $error("output or queue busy after reset");

endmodule

`default_nettype wire

// ===== sim/lns_checker.sv =====
// ----------------------------------------------------------------------------
// lns_checker
// watches the mode, byte and sample channels of the noise sampler, predicts
// every sample from the accepted bytes and compares it with what comes out
// ----------------------------------------------------------------------------

module lns_checker import lns_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [1:0] cfg_data,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,
  input  wire logic       out_tlast,
  output int              fail_count,
  output int              pending_results,
  output int              results_seen
);

  typedef struct packed {
    logic [1:0] sample;
    logic       last;
  } noise_sample_t;

  noise_sample_t sample_queue[$];
  mode_t         cur_mode = MODE_BIT_PAIR;
  logic [15:0]   chunk_bits = '0;
  logic [1:0]    chunk_bytes = '0;
  int            mismatch_count = 0;
  int            result_count = 0;

  function automatic void queue_sample(logic [1:0] s);
    noise_sample_t item;
    item.sample = s;
    item.last   = 1'b0;
    sample_queue.push_back(item);
  endfunction

  task automatic predict_samples(input logic [7:0] b, input logic fin);
    int          first;
    int          k;
    logic [23:0] chunk;
    logic [2:0]  cand;
    logic [3:0]  nib;
    logic [1:0]  s;
    first = sample_queue.size();
    case (cur_mode)
      MODE_BIT_PAIR: begin
        for (k = 0; k < 4; k++) begin
          s = {1'b0, b[2*k+1]} - {1'b0, b[2*k]};
          queue_sample(s);
        end
      end
      MODE_ZERO_PAIR: begin
        for (k = 0; k < 2; k++) begin
          nib = b[4*k +: 4];
          s = {1'b0, nib[1:0] == 2'b00} - {1'b0, nib[3:2] == 2'b00};
          queue_sample(s);
        end
      end
      MODE_REJ_SIX: begin
        if (chunk_bytes == 2'd2) begin
          chunk = {b, chunk_bits};
          for (k = 0; k < 8; k++) begin
            cand = chunk[3*k +: 3] & CAND_MASK;
            if (cand < CAND_LIMIT) queue_sample({1'b0, cand == 3'd0});
          end
          chunk_bits  = '0;
          chunk_bytes = 2'd0;
        end else if (chunk_bytes == 2'd1) begin
          chunk_bits[15:8] = b;
          chunk_bytes      = 2'd2;
        end else begin
          chunk_bits  = {8'h00, b};
          chunk_bytes = 2'd1;
        end
      end
      default: begin
        for (k = 0; k < 2; k++) begin
          nib = b[4*k +: 4];
          if (nib < NIB_LIMIT) queue_sample({1'b0, nib == 4'd0});
        end
      end
    endcase
    if (fin) begin
      chunk_bits  = '0;
      chunk_bytes = 2'd0;
    end
    if (sample_queue.size() > first) sample_queue[sample_queue.size()-1].last = 1'b1;
  endtask

  task automatic check_sample();
    noise_sample_t want;
    result_count++;
    if (sample_queue.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("checker: unexpected sample, tdata %02h last %0b", out_tdata, out_tlast);
    end else begin
      want = sample_queue.pop_front();
      if (out_tdata[1:0] !== want.sample || out_tdata[7:2] !== 6'd0 ||
          out_tlast !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("checker: sample %0d, expected sample %0d last %0b, got tdata %02h last %0b",
                   result_count, $signed(want.sample), want.last, out_tdata, out_tlast);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode    = MODE_BIT_PAIR;
      chunk_bits  = '0;
      chunk_bytes = 2'd0;
      sample_queue.delete();
    end else begin
      if (out_tvalid && out_tready) check_sample();
      if (cfg_valid && cfg_ready) begin
        cur_mode    = mode_t'(cfg_data);
        chunk_bits  = '0;
        chunk_bytes = 2'd0;
      end
      if (in_tvalid && in_tready) predict_samples(in_tdata, in_tlast);
    end
    fail_count      <= mismatch_count;
    pending_results <= sample_queue.size();
    results_seen    <= result_count;
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives random bytes and mode writes into the noise sampler with random
// gaps and output stalls; the checker predicts and compares every sample
// ----------------------------------------------------------------------------

module testbench;
  import lns_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int BYTE_TARGET = 455;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = 2'd0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int   fail_count;
  int   pending_results;
  int   results_seen;
  int   sent_bytes = 0;
  int   mode_writes = 0;
  int   idle_cycles = 0;
  int   hold_left = 0;
  logic quiet_link = 1'b0;

  always #2 clk = ~clk;

  lattice_noise_sampler_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lns_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_seen    (results_seen)
  );

  // receiver stalls, mostly short
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (rst_n && !quiet_link && $urandom_range(0, 99) < 20) begin
      hold_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("testbench: no progress for %0d cycles", STALL_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_link || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] draw_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(0, 255));
    if (r < 95) return 8'($urandom_range(0, 255) & $urandom_range(0, 255));
    return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // a byte that yields nothing may still be in flight, so let the pipe settle
  task automatic write_mode(input mode_t m);
    drain_results();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  task automatic run_phase(input mode_t m, input int len);
    int   done;
    int   n;
    int   k;
    logic fin;
    done = 0;
    while (done < len) begin
      if ($urandom_range(0, 49) == 0) drain_results();
      if (m == MODE_REJ_SIX) begin
        if ($urandom_range(0, 99) < 85) begin
          // whole chunk, sometimes closed by the final flag
          fin = ($urandom_range(0, 6) == 0);
          send_byte(draw_byte(), 1'b0);
          send_byte(draw_byte(), 1'b0);
          send_byte(draw_byte(), fin);
          done += 3;
        end else begin
          // broken chunk cut short by the final flag
          n = $urandom_range(1, 2);
          for (k = 0; k < n; k++) send_byte(draw_byte(), k == n - 1);
          done += n;
        end
      end else begin
        send_byte(draw_byte(), $urandom_range(0, 9) == 0);
        done++;
      end
    end
  endtask

  initial begin
    mode_t m;
    int    phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset mode, bit-pair difference
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b1);

    write_mode(MODE_ZERO_PAIR);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hc3, 1'b1);

    // all-zero chunk, all-rejected chunk, dropped partial chunk
    write_mode(MODE_REJ_SIX);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h88, 1'b0);
    send_byte(8'h88, 1'b0);
    send_byte(8'h88, 1'b1);
    // a mode write drops the open chunk
    send_byte(8'hff, 1'b0);
    write_mode(MODE_REJ_SIX);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);

    write_mode(MODE_REJ_TWLV);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hcb, 1'b0);
    send_byte(8'h0c, 1'b1);

    phase = 0;
    while (sent_bytes < BYTE_TARGET) begin
      case (phase)
        0:       m = MODE_REJ_TWLV;
        1:       m = MODE_BIT_PAIR;
        2:       m = MODE_REJ_SIX;
        3:       m = MODE_ZERO_PAIR;
        default: m = mode_t'($urandom_range(0, 3));
      endcase
      write_mode(m);
      quiet_link = ($urandom_range(0, 3) == 0);
      run_phase(m, $urandom_range(30, 60));
      phase++;
    end

    drain_results();
    quiet_link = 1'b0;
    repeat (20) @(posedge clk);
    $display("testbench: %0d bytes over %0d mode writes, %0d samples compared",
             sent_bytes, mode_writes, results_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: %0d mismatches", fail_count);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
